// ===== sv/pmam_pkg.sv =====
// ----------------------------------------------------------------------------
// pmam_pkg
// Shared types and constants for the paged memory address mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pmam_pkg;

  // Configuration port
  localparam int CfgIndexWidth = 4;
  localparam int CfgDataWidth  = 32;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_RAM_MAP_INIT   = 4'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_VALID_MAP_INIT = 4'd1;

  // Map reset values
  localparam logic [31:0] RamMapReset   = 32'h0000_ffff;
  localparam logic [31:0] ValidMapReset = 32'h3fff_ffff;

  // Map bits covering window 2 (address 0100000-0137777)
  localparam logic [31:0] RomWindowBits = 32'h00ff_0000;

  // Bank codes
  localparam logic [3:0] BANK_RAM1   = 4'd1;
  localparam logic [3:0] BANK_RAM6   = 4'd6;
  localparam logic [3:0] BANK_RAM7   = 4'd7;
  localparam logic [3:0] BANK_ROM0   = 4'd8;
  localparam logic [3:0] BANK_ROM1   = 4'd9;
  localparam logic [3:0] BANK_ROM2   = 4'd10;
  localparam logic [3:0] BANK_ROM3   = 4'd11;
  localparam logic [3:0] BANK_SYSROM = 4'd12;

  // ROM select codes, page value bits 4,3,1,0
  localparam logic [3:0] ROM_CODE_NONE = 4'b0000;
  localparam logic [3:0] ROM_CODE_P0   = 4'b0001;
  localparam logic [3:0] ROM_CODE_P1   = 4'b0010;
  localparam logic [3:0] ROM_CODE_P2   = 4'b0100;
  localparam logic [3:0] ROM_CODE_P3   = 4'b1000;

  // Request types
  typedef enum logic [2:0] {
    REQ_READ_WORD  = 3'd0,
    REQ_WRITE_WORD = 3'd1,
    REQ_WRITE_BYTE = 3'd2,
    REQ_PAGE_WORD  = 3'd3,
    REQ_PAGE_BYTE  = 3'd4
  } req_t;

  // Routes
  localparam logic [1:0] ROUTE_PAGE   = 2'd0;
  localparam logic [1:0] ROUTE_MEMORY = 2'd1;
  localparam logic [1:0] ROUTE_DEVICE = 2'd2;

  // Video pages
  localparam logic [1:0] VIDEO_NONE  = 2'd0;
  localparam logic [1:0] VIDEO_PAGE1 = 2'd1;
  localparam logic [1:0] VIDEO_PAGE7 = 2'd2;

  // Page register update command
  typedef struct packed {
    logic        word_wr;
    logic        byte_wr;
    logic [15:0] value;
  } page_cmd_t;

  // Current mapping state
  typedef struct packed {
    logic [3:0]  win1_bank;
    logic [3:0]  win2_bank;
    logic [31:0] wr_map;
    logic [31:0] rd_map;
  } page_state_t;

endpackage

`default_nettype wire

// ===== sv/pmam_if.sv =====
// ----------------------------------------------------------------------------
// pmam_if
// Request and response channel interfaces for the address mapper.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmam_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] address;
  logic [15:0] data;

  modport source (output valid, output req_type, output address, output data,
                  input ready);
  modport sink   (input valid, input req_type, input address, input data,
                  output ready);
endinterface

interface pmam_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  route;
  logic [3:0]  bank;
  logic [12:0] word_offset;
  logic [1:0]  byte_enable;
  logic [1:0]  disp_page;
  logic [13:0] screen_offset;

  modport source (output valid, output route, output bank, output word_offset,
                  output byte_enable, output disp_page, output screen_offset,
                  input ready);
  modport sink   (input valid, input route, input bank, input word_offset,
                  input byte_enable, input disp_page, input screen_offset,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pmam_page_regs.sv =====
// ----------------------------------------------------------------------------
// pmam_page_regs
// Page register, window bank selects and the writable / readable maps.
// ----------------------------------------------------------------------------
`default_nettype none

module pmam_page_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pmam_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [pmam_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire pmam_pkg::page_cmd_t                cmd,
  output pmam_pkg::page_state_t                   state
);

  logic [15:0] last_value;
  logic [15:0] last_value_next;
  logic [3:0]  win1_bank;
  logic [3:0]  win1_bank_next;
  logic [3:0]  win2_bank;
  logic [3:0]  win2_bank_next;
  logic [31:0] wr_map;
  logic [31:0] wr_map_next;
  logic [31:0] rd_map;
  logic [31:0] rd_map_next;
  logic [3:0]  rom_code;
  logic [7:0]  byte_val;

  assign rom_code = {cmd.value[4], cmd.value[3], cmd.value[1], cmd.value[0]};
  assign byte_val = cmd.value[7:0];

  // Next state for page register writes and config loads
  always_comb begin
    last_value_next = last_value;
    win1_bank_next  = win1_bank;
    win2_bank_next  = win2_bank;
    wr_map_next     = wr_map;
    rd_map_next     = rd_map;

    if (cmd.word_wr && cmd.value != last_value) begin
      last_value_next = cmd.value;
      win1_bank_next  = {1'b0, cmd.value[14:12]};
      win2_bank_next  = {1'b0, cmd.value[10:8]};
      case (rom_code)
        pmam_pkg::ROM_CODE_NONE: begin
          wr_map_next = wr_map | pmam_pkg::RomWindowBits;
          rd_map_next = rd_map | pmam_pkg::RomWindowBits;
        end
        pmam_pkg::ROM_CODE_P0: begin
          win2_bank_next = pmam_pkg::BANK_ROM0;
          wr_map_next    = wr_map & ~pmam_pkg::RomWindowBits;
          rd_map_next    = rd_map | pmam_pkg::RomWindowBits;
        end
        pmam_pkg::ROM_CODE_P1: begin
          win2_bank_next = pmam_pkg::BANK_ROM1;
          wr_map_next    = wr_map & ~pmam_pkg::RomWindowBits;
          rd_map_next    = rd_map | pmam_pkg::RomWindowBits;
        end
        pmam_pkg::ROM_CODE_P2: begin
          win2_bank_next = pmam_pkg::BANK_ROM2;
          wr_map_next    = wr_map & ~pmam_pkg::RomWindowBits;
          rd_map_next    = rd_map & ~pmam_pkg::RomWindowBits;
        end
        pmam_pkg::ROM_CODE_P3: begin
          win2_bank_next = pmam_pkg::BANK_ROM3;
          wr_map_next    = wr_map & ~pmam_pkg::RomWindowBits;
          rd_map_next    = rd_map & ~pmam_pkg::RomWindowBits;
        end
        default: begin
          // unknown ROM code: maps untouched
        end
      endcase
    end else if (cmd.byte_wr && byte_val != last_value[15:8]) begin
      last_value_next = {byte_val, last_value[7:0]};
      win1_bank_next  = {1'b0, byte_val[6:4]};
      win2_bank_next  = {1'b0, byte_val[2:0]};
    end

    // config write reloads a map
    if (cfg_we && cfg_index == pmam_pkg::CFG_RAM_MAP_INIT) begin
      wr_map_next = cfg_data;
    end
    if (cfg_we && cfg_index == pmam_pkg::CFG_VALID_MAP_INIT) begin
      rd_map_next = cfg_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_value <= '0;
      win1_bank  <= pmam_pkg::BANK_RAM1;
      win2_bank  <= pmam_pkg::BANK_ROM0;
      wr_map     <= pmam_pkg::RamMapReset;
      rd_map     <= pmam_pkg::ValidMapReset;
    end else begin
      last_value <= last_value_next;
      win1_bank  <= win1_bank_next;
      win2_bank  <= win2_bank_next;
      wr_map     <= wr_map_next;
      rd_map     <= rd_map_next;
    end
  end

  assign state.win1_bank = win1_bank;
  assign state.win2_bank = win2_bank;
  assign state.wr_map    = wr_map;
  assign state.rd_map    = rd_map;

endmodule

`default_nettype wire

// ===== sv/paged_memory_address_mapper.sv =====
// ----------------------------------------------------------------------------
// paged_memory_address_mapper
// Translates 16-bit bus addresses through four 16 KB windows.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat: req_type, address and data. Reads and
//   writes are translated against the current window banks and maps;
//   page register beats update the window selects and maps.
//   rsp returns exactly one beat per request: route, bank, word offset,
//   byte enables, video page and screen offset.
//   cfg_we / cfg_index / cfg_data reload the writable (index 0) or
//   readable (index 1) map; write only while no beat is in flight.
// Timing and throughput:
//   A request beat is translated in the cycle it is taken and its
//   response appears in the next cycle from the response register. One
//   beat per cycle is sustained while rsp is not stalled; the
//   translation is a single level of map bit select and window mux.
// Reset:
//   rst (synchronous) empties the response register and restores the
//   page register, window banks and maps; req.ready is low during reset.
// Backpressure:
//   While rsp is stalled with a beat held, req.ready stays low; the
//   request side is taken again in the cycle the held beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_memory_address_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pmam_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [pmam_pkg::CfgDataWidth-1:0]  cfg_data,
  pmam_req_if.sink                                req,
  pmam_rsp_if.source                              rsp
);

  pmam_pkg::page_cmd_t   cmd;
  pmam_pkg::page_state_t st;
  pmam_pkg::req_t        rtype;

  logic        accept;
  logic        out_valid;
  logic [1:0]  out_route;
  logic [3:0]  out_bank;
  logic [12:0] out_woff;
  logic [1:0]  out_be;
  logic [1:0]  out_vid;
  logic [13:0] out_soff;

  logic [1:0]  route_next;
  logic [3:0]  bank_next;
  logic [12:0] woff_next;
  logic [1:0]  be_next;
  logic [1:0]  vid_next;
  logic [13:0] soff_next;

  logic [15:0] addr;
  logic [3:0]  win_bank;
  logic [1:0]  win_vid;
  logic        hit;

  // Handshake: response register frees when empty or being taken
  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rtype     = pmam_pkg::req_t'(req.req_type);

  assign cmd.word_wr = accept && rtype == pmam_pkg::REQ_PAGE_WORD;
  assign cmd.byte_wr = accept && rtype == pmam_pkg::REQ_PAGE_BYTE;
  assign cmd.value   = req.data;

  pmam_page_regs u_page_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .state     (st)
  );

  // Word accesses drop address bit 0
  assign addr = (rtype == pmam_pkg::REQ_WRITE_BYTE) ? req.address
                                                    : {req.address[15:1], 1'b0};

  // Window to bank
  always_comb begin
    case (addr[15:14])
      2'd0:    win_bank = pmam_pkg::BANK_RAM6;
      2'd1:    win_bank = st.win1_bank;
      2'd2:    win_bank = st.win2_bank;
      default: win_bank = pmam_pkg::BANK_SYSROM;
    endcase
  end

  assign win_vid = (win_bank == pmam_pkg::BANK_RAM1) ? pmam_pkg::VIDEO_PAGE1 :
                   (win_bank == pmam_pkg::BANK_RAM7) ? pmam_pkg::VIDEO_PAGE7 :
                                                       pmam_pkg::VIDEO_NONE;

  // Translation
  always_comb begin
    route_next = pmam_pkg::ROUTE_PAGE;
    bank_next  = '0;
    woff_next  = '0;
    be_next    = '0;
    vid_next   = pmam_pkg::VIDEO_NONE;
    soff_next  = '0;
    hit        = 1'b0;
    case (rtype)
      pmam_pkg::REQ_READ_WORD,
      pmam_pkg::REQ_WRITE_WORD,
      pmam_pkg::REQ_WRITE_BYTE: begin
        if (rtype == pmam_pkg::REQ_WRITE_BYTE) begin
          be_next = addr[0] ? 2'b10 : 2'b01;
        end else begin
          be_next = 2'b11;
        end
        if (rtype == pmam_pkg::REQ_READ_WORD) begin
          hit = st.rd_map[addr[15:11]];
        end else begin
          hit = st.wr_map[addr[15:11]];
        end
        if (hit) begin
          route_next = pmam_pkg::ROUTE_MEMORY;
          bank_next  = win_bank;
          woff_next  = addr[13:1];
          vid_next   = win_vid;
          if (rtype != pmam_pkg::REQ_READ_WORD && win_vid != pmam_pkg::VIDEO_NONE) begin
            soff_next = {addr[13:1], 1'b0};
          end
        end else begin
          route_next = pmam_pkg::ROUTE_DEVICE;
        end
      end
      pmam_pkg::REQ_PAGE_WORD,
      pmam_pkg::REQ_PAGE_BYTE: begin
        route_next = pmam_pkg::ROUTE_PAGE;
      end
      default: begin
        // undefined request: all fields zero
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.ready) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_route <= route_next;
      out_bank  <= bank_next;
      out_woff  <= woff_next;
      out_be    <= be_next;
      out_vid   <= vid_next;
      out_soff  <= soff_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.route         = out_route;
  assign rsp.bank          = out_bank;
  assign rsp.word_offset   = out_woff;
  assign rsp.byte_enable   = out_be;
  assign rsp.disp_page     = out_vid;
  assign rsp.screen_offset = out_soff;

endmodule

`default_nettype wire
